/* rtl/swpc_pkg.sv */
// ----------------------------------------------------------------------------
// swpc_pkg
// Shared types and constants for the stopwatch / press counter display unit.
// ----------------------------------------------------------------------------
package swpc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_BUTTON = 2'd1,
        CMD_START  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_ELAPSED = 2'd0,
        JOB_PRESS   = 2'd1,
        JOB_SETUP   = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] digits;
    } job_t;

    typedef enum logic [1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_SCAN_LIMIT = 2'd1,
        CFG_DECODE     = 2'd2
    } cfg_idx_t;

    localparam logic [3:0] REG_DECODE    = 4'h9;
    localparam logic [3:0] REG_INTENSITY = 4'hA;
    localparam logic [3:0] REG_SCAN      = 4'hB;
    localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
    localparam logic [7:0] SHUTDOWN_RUN  = 8'h01;

    localparam logic [3:0] ELAPSED_BASE  = 4'd1;
    localparam logic [3:0] PRESS_BASE    = 4'd5;
    localparam logic [3:0] DIGIT_LAST    = 4'd3;
    localparam logic [3:0] SETUP_FIRST_DIGIT = 4'd4;
    localparam logic [3:0] SETUP_LAST    = 4'd11;

    localparam logic [3:0] BRIGHT_RST    = 4'd2;
    localparam logic [2:0] SCAN_RST      = 3'd7;
    localparam logic [7:0] DECODE_RST    = 8'hFF;

    // decimal increment over four BCD digits, nibbles above 9 roll like 9
    function automatic logic [15:0] bcd_inc(input logic [15:0] v);
        logic [15:0] res;
        logic        carry;
        logic [3:0]  d;
        res   = '0;
        carry = 1'b1;
        for (int k = 0; k < 4; k++) begin
            d = v[4*k +: 4];
            if (carry) begin
                if (d >= 4'd9) begin
                    d = 4'd0;
                end else begin
                    d     = d + 4'd1;
                    carry = 1'b0;
                end
            end
            res[4*k +: 4] = d;
        end
        return res;
    endfunction

endpackage

/* rtl/stopwatch_press_counter_display_unit.sv */
// ----------------------------------------------------------------------------
// stopwatch_press_counter_display_unit
// Stopwatch and press counter producing display driver register writes.
// ----------------------------------------------------------------------------
// Path: an accepted input word is registered in the job queue; when the write
// sequencer is idle, its first write word goes from the queue head to the output register.
// Throughput: one input word per cycle while the two-entry job queue has room;
// writes leave one per cycle while the receiver is ready, a tick or press
// expands to 4 writes, a start to 12, jobs back to back; the sequencer sets the rate.
// Reset: synchronous on aresetn low; counts and pause cleared, debounce history
// all released, configuration back to its defaults, queue emptied.
module stopwatch_press_counter_display_unit import swpc_pkg::*; #(
    parameter int DEBOUNCE_LEN = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] reg_address, [11:4] reg_data, [15:12] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    job_t       q_in_job;
    job_t       q_head;
    logic [3:0] w_addr;
    logic [7:0] w_data;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;

    swpc_front #(
        .DEBOUNCE_LEN(DEBOUNCE_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_accept (s_tready),
        .in_cmd    (s_tuser),
        .in_level  (s_tdata[0]),
        .push      (q_push),
        .push_job  (q_in_job)
    );

    swpc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in_job),
        .pop      (q_pop),
        .head_job (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    swpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_addr  (w_addr),
        .out_data  (w_data),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, w_data, w_addr};

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty))
        else $error("job popped from empty queue");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

/* rtl/swpc_front.sv */
// ----------------------------------------------------------------------------
// swpc_front
// Accepts input words, updates counts, pause flag and debounce history,
// and queues a write job for every word that produces display writes.
// ----------------------------------------------------------------------------
module swpc_front import swpc_pkg::*; #(
    parameter int DEBOUNCE_LEN = 10
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       in_accept,
    input  logic [1:0] in_cmd,
    input  logic       in_level,
    output logic       push,
    output job_t       push_job
);

    logic [15:0]             elapsed_reg, elapsed_next;
    logic [15:0]             press_reg, press_next;
    logic                    paused_reg, paused_next;
    logic [DEBOUNCE_LEN-1:0] history_reg, history_next;
    logic [DEBOUNCE_LEN-1:0] history_shift;

    assign history_shift = {history_reg[DEBOUNCE_LEN-2:0], in_level};

    always_comb begin
        elapsed_next    = elapsed_reg;
        press_next      = press_reg;
        paused_next     = paused_reg;
        history_next    = history_reg;
        push            = 1'b0;
        push_job.kind   = JOB_SETUP;
        push_job.digits = '0;
        if (in_valid && in_accept) begin
            unique case (cmd_t'(in_cmd))
                CMD_TICK: begin
                    if (!paused_reg) begin
                        elapsed_next = bcd_inc(elapsed_reg);
                    end
                    push            = 1'b1;
                    push_job.kind   = JOB_ELAPSED;
                    push_job.digits = elapsed_next;
                end
                CMD_BUTTON: begin
                    history_next = history_shift;
                    if (history_shift == '0) begin
                        paused_next     = !paused_reg;
                        press_next      = bcd_inc(press_reg);
                        push            = 1'b1;
                        push_job.kind   = JOB_PRESS;
                        push_job.digits = press_next;
                    end
                end
                CMD_START: begin
                    push          = 1'b1;
                    push_job.kind = JOB_SETUP;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            press_reg   <= '0;
            paused_reg  <= 1'b0;
            history_reg <= '1;
        end else begin
            elapsed_reg <= elapsed_next;
            press_reg   <= press_next;
            paused_reg  <= paused_next;
            history_reg <= history_next;
        end
    end

endmodule

/* rtl/swpc_fifo.sv */
// ----------------------------------------------------------------------------
// swpc_fifo
// Two-entry job queue between the front and the write sequencer.
// ----------------------------------------------------------------------------
module swpc_fifo import swpc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = !wptr_reg;
        end
        if (pop) begin
            rptr_next = !rptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/swpc_back.sv */
// ----------------------------------------------------------------------------
// swpc_back
// Write sequencer: holds the configuration registers, expands each queued
// job into display register writes and drives the output register.
// ----------------------------------------------------------------------------
module swpc_back import swpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        q_empty,
    input  job_t        q_head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  out_addr,
    output logic [7:0]  out_data,
    output logic        out_last
);

    logic [3:0]  bright_reg;
    logic [2:0]  scan_reg;
    logic [7:0]  decode_reg;

    logic        active_reg, active_next;
    job_t        job_reg, job_next;
    logic [3:0]  idx_reg, idx_next;

    logic        ovalid_reg, ovalid_next;
    logic [3:0]  oaddr_reg, oaddr_next;
    logic [7:0]  odata_reg, odata_next;
    logic        olast_reg, olast_next;

    job_t        cur_job;
    logic [3:0]  cur_idx;
    logic        cur_valid;
    logic        out_load;
    logic        advance;
    logic [3:0]  w_addr;
    logic [7:0]  w_data;
    logic        w_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= BRIGHT_RST;
            scan_reg   <= SCAN_RST;
            decode_reg <= DECODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BRIGHTNESS: bright_reg <= cfg_data[3:0];
                CFG_SCAN_LIMIT: scan_reg   <= cfg_data[2:0];
                CFG_DECODE:     decode_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cur_job   = active_reg ? job_reg : q_head;
    assign cur_idx   = active_reg ? idx_reg : 4'd0;
    assign cur_valid = active_reg || !q_empty;
    assign out_load  = !ovalid_reg || out_ready;
    assign advance   = cur_valid && out_load;
    assign pop       = !active_reg && !q_empty && out_load;

    always_comb begin
        w_addr = '0;
        w_data = '0;
        w_last = 1'b0;
        unique case (cur_job.kind)
            JOB_ELAPSED, JOB_PRESS: begin
                w_addr = ((cur_job.kind == JOB_PRESS) ? PRESS_BASE : ELAPSED_BASE) + cur_idx;
                w_data = {4'd0, cur_job.digits[{cur_idx[1:0], 2'b00} +: 4]};
                w_last = (cur_idx == DIGIT_LAST);
            end
            JOB_SETUP: begin
                unique case (cur_idx)
                    4'd0: begin
                        w_addr = REG_DECODE;
                        w_data = decode_reg;
                    end
                    4'd1: begin
                        w_addr = REG_INTENSITY;
                        w_data = {4'd0, bright_reg};
                    end
                    4'd2: begin
                        w_addr = REG_SCAN;
                        w_data = {5'd0, scan_reg};
                    end
                    4'd3: begin
                        w_addr = REG_SHUTDOWN;
                        w_data = SHUTDOWN_RUN;
                    end
                    default: begin
                        w_addr = cur_idx - SETUP_FIRST_DIGIT + 4'd1;
                        w_data = '0;
                    end
                endcase
                w_last = (cur_idx == SETUP_LAST);
            end
            default: ;
        endcase
    end

    always_comb begin
        active_next = active_reg;
        job_next    = job_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        oaddr_next  = oaddr_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        if (out_load) begin
            ovalid_next = advance;
            oaddr_next  = w_addr;
            odata_next  = w_data;
            olast_next  = w_last;
        end
        if (advance) begin
            if (w_last) begin
                active_next = 1'b0;
            end else begin
                active_next = 1'b1;
                job_next    = cur_job;
                idx_next    = cur_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        idx_reg   <= idx_next;
        oaddr_reg <= oaddr_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_addr  = oaddr_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

endmodule

/* dv/stopwatch_press_counter_display_unit_tb.sv */
// ----------------------------------------------------------------------------
// stopwatch_press_counter_display_unit_tb
// Self-checking bench: drives ticks, button samples and start words, predicts
// every display register write in a cycle-free model of the counters and the
// debounce history, and compares each write word as it leaves the block.
// ----------------------------------------------------------------------------
module stopwatch_press_counter_display_unit_tb;
    import swpc_pkg::*;

    localparam int DEBOUNCE_LEN   = 10;
    localparam int SETTLE_CYCLES  = 40;
    localparam int IDLE_LIMIT     = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_EVENTS   = 100;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic       level;
    } panel_event_t;

    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] data;
        logic       last;
    } reg_write_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_MOSTLY,
        RX_COMB
    } rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [0] button_level, [7:1] zero
    logic [1:0]  s_tuser   = CMD_TICK; // [1:0] command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [3:0] reg_address, [11:4] reg_data, [15:12] zero
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BRIGHTNESS;
    logic [7:0]  cfg_data  = 8'h00;

    panel_event_t panel_events[$];
    reg_write_t   display_writes_due[$];

    // predicted block state
    logic [15:0]             elapsed_bcd;
    logic [15:0]             press_bcd;
    logic                    paused_now;
    logic [DEBOUNCE_LEN-1:0] button_history;
    logic [3:0]              cfg_brightness;
    logic [2:0]              cfg_scan;
    logic [7:0]              cfg_decode;

    int mismatches   = 0;
    int words_seen   = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    int pattern_left = 0;
    int rx_phase     = 0;
    rx_mode_t rx_mode = RX_FREE;

    stopwatch_press_counter_display_unit #(
        .DEBOUNCE_LEN(DEBOUNCE_LEN)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [15:0] decimal_count_up(input logic [15:0] v);
        logic [15:0] r;
        logic        carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (carry) begin
                if (r[4*i +: 4] >= 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic queue_write(input logic [3:0] addr, input logic [7:0] data,
                               input logic last);
        reg_write_t w;
        w.addr = addr;
        w.data = data;
        w.last = last;
        display_writes_due.push_back(w);
    endtask

    task automatic queue_digits(input logic [15:0] bcd, input logic [3:0] base);
        for (int k = 0; k < 4; k++)
            queue_write(base + 4'(k), {4'h0, bcd[4*k +: 4]}, k == 3);
    endtask

    task automatic advance_panel(input logic [1:0] command, input logic level);
        case (command)
            CMD_TICK: begin
                if (!paused_now)
                    elapsed_bcd = decimal_count_up(elapsed_bcd);
                queue_digits(elapsed_bcd, ELAPSED_BASE);
            end
            CMD_BUTTON: begin
                button_history = {button_history[DEBOUNCE_LEN-2:0], level};
                if (button_history == '0) begin
                    paused_now = !paused_now;
                    press_bcd  = decimal_count_up(press_bcd);
                    queue_digits(press_bcd, PRESS_BASE);
                end
            end
            CMD_START: begin
                queue_write(REG_DECODE, cfg_decode, 1'b0);
                queue_write(REG_INTENSITY, {4'h0, cfg_brightness}, 1'b0);
                queue_write(REG_SCAN, {5'h00, cfg_scan}, 1'b0);
                queue_write(REG_SHUTDOWN, SHUTDOWN_RUN, 1'b0);
                for (int k = 0; k < 8; k++)
                    queue_write(ELAPSED_BASE + 4'(k), 8'h00, k == 7);
            end
            default: begin
            end
        endcase
    endtask

    task automatic add_event(input logic [1:0] command, input logic level);
        panel_event_t ev;
        ev.command = command;
        ev.level   = level;
        panel_events.push_back(ev);
    endtask

    // mostly clean presses and ticks, some bounce and stray samples
    task automatic add_random_events(input int target);
        int counted;
        int pick;
        int n;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_event(CMD_TICK, 1'($urandom_range(0, 1)));
                counted++;
            end else if (pick < 70) begin
                n = $urandom_range(0, 4);
                repeat (n) add_event(CMD_BUTTON, 1'($urandom_range(0, 1)));
                counted += n;
                n = $urandom_range(DEBOUNCE_LEN, DEBOUNCE_LEN + 3);
                repeat (n) add_event(CMD_BUTTON, 1'b0);
                counted += n;
                n = $urandom_range(1, 3);
                repeat (n) add_event(CMD_BUTTON, 1'b1);
                counted += n;
            end else if (pick < 80) begin
                add_event(CMD_BUTTON, 1'($urandom_range(0, 1)));
                counted++;
            end else if (pick < 90) begin
                add_event(CMD_START, 1'($urandom_range(0, 1)));
                counted++;
            end else begin
                add_event(CMD_UNUSED, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic drain_and_settle();
        do @(negedge aclk);
        while (panel_events.size() != 0 || s_tvalid || display_writes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_BRIGHTNESS: cfg_brightness = val[3:0];
            CFG_SCAN_LIMIT: cfg_scan       = val[2:0];
            CFG_DECODE:     cfg_decode     = val;
            default: begin
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_config(input logic [7:0] bright, input logic [7:0] scan,
                                input logic [7:0] decode, input logic [7:0] junk);
        write_reg(CFG_DECODE, decode);
        write_reg(CFG_BRIGHTNESS, bright);
        write_reg(CFG_UNUSED_IDX, junk);
        write_reg(CFG_SCAN_LIMIT, scan);
        @(negedge aclk);
    endtask

    // input driver with prediction at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid       <= 1'b0;
            elapsed_bcd    = 16'h0000;
            press_bcd      = 16'h0000;
            paused_now     = 1'b0;
            button_history = '1;
            cfg_brightness = BRIGHT_RST;
            cfg_scan       = SCAN_RST;
            cfg_decode     = DECODE_RST;
        end else begin
            if (s_tvalid && s_tready)
                advance_panel(s_tuser, s_tdata[0]);
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (panel_events.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= panel_events[0].command;
                    s_tdata  <= {7'h00, panel_events[0].level};
                    void'(panel_events.pop_front());
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                            8:          gap_left = $urandom_range(5, 15);
                            default:    gap_left = $urandom_range(20, 40);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // write monitor and receiver stall pattern
    always @(posedge aclk) begin
        reg_write_t want;
        logic       rdy;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (words_seen == 150 || words_seen == 30000)
                    hold_left = LONG_HOLD;
                if (display_writes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected write word: addr %h data %h last %b",
                                 m_tdata[3:0], m_tdata[11:4], m_tlast);
                end else begin
                    want = display_writes_due.pop_front();
                    if (m_tdata[3:0] !== want.addr || m_tdata[11:4] !== want.data ||
                        m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("word %0d: exp %h/%h/%b got %h/%h/%b",
                                     words_seen, want.addr, want.data, want.last,
                                     m_tdata[3:0], m_tdata[11:4], m_tlast);
                    end
                end
            end
            if (pattern_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 120);
            end else begin
                pattern_left--;
            end
            rx_phase = (rx_phase + 1) % 5;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   rdy = 1'b1;
                    RX_COIN:   rdy = 1'($urandom_range(0, 1));
                    RX_MOSTLY: rdy = ($urandom_range(0, 7) != 0);
                    default:   rdy = (rx_phase != 0 && rx_phase != 3);
                endcase
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("stopwatch_press_counter_display_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset configuration, counting, pause on a held press and release
        add_event(CMD_START, 1'b0);
        add_event(CMD_TICK, 1'b0);
        add_event(CMD_TICK, 1'b1);
        add_event(CMD_UNUSED, 1'b0);
        add_event(CMD_UNUSED, 1'b1);
        add_event(CMD_TICK, 1'b1);
        repeat (DEBOUNCE_LEN) add_event(CMD_BUTTON, 1'b0);
        add_event(CMD_TICK, 1'b0);
        add_event(CMD_BUTTON, 1'b0);
        add_event(CMD_BUTTON, 1'b1);
        add_event(CMD_BUTTON, 1'b0);
        add_event(CMD_TICK, 1'b0);
        add_event(CMD_START, 1'b1);
        drain_and_settle();

        write_config(8'h00, 8'h00, 8'h00, 8'h00);
        add_random_events(PHASE_EVENTS);
        drain_and_settle();

        write_config(8'h0F, 8'h07, 8'hFF, 8'hFF);
        add_random_events(PHASE_EVENTS);
        drain_and_settle();

        write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        add_random_events(PHASE_EVENTS);
        drain_and_settle();

        write_config(8'($urandom_range(0, 15)), 8'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        add_random_events(PHASE_EVENTS);
        drain_and_settle();

        add_event(CMD_START, 1'b0);
        add_event(CMD_TICK, 1'b0);
        drain_and_settle();

        mismatches += display_writes_due.size();
        if (mismatches == 0)
            $display("stopwatch_press_counter_display_unit test passed");
        else
            $display("stopwatch_press_counter_display_unit test failed");
        $finish;
    end

endmodule
